@@ design/assert_macros.svh @@
// Assertion macros used by the line generator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define BLG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge at which reset is held.
`define BLG_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) !rst_n |-> prop) else $error(msg);
`else
`define BLG_ASSERT(lbl, clk, rst_n, prop, msg)
`define BLG_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`endif
`endif

@@ design/blg_pkg.sv @@
// Types and constants of the Bresenham line pixel generator.
package blg_pkg;

  localparam int unsigned SCREEN_WIDTH  = 480;
  localparam int unsigned SCREEN_HEIGHT = 272;
  localparam int unsigned STEP_MARGIN   = 4;
  localparam int unsigned STEP_LIMIT    = SCREEN_WIDTH + SCREEN_HEIGHT + STEP_MARGIN;
  localparam int unsigned STEP_W        = $clog2(STEP_LIMIT + 1);

  localparam int unsigned COORD_W = 16;
  localparam int unsigned COLOR_W = 16;
  localparam int unsigned ADDR_W  = 17;
  localparam int unsigned ERR_W   = 18;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_TICK = 1'b1
  } action_e;

  typedef struct packed {
    action_e              action;
    logic [COORD_W-1:0]   start_x;
    logic [COORD_W-1:0]   start_y;
    logic [COORD_W-1:0]   end_x;
    logic [COORD_W-1:0]   end_y;
    logic [COLOR_W-1:0]   line_color;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0]   pixel_x;
    logic [COORD_W-1:0]   pixel_y;
    logic [ADDR_W-1:0]    pixel_address;
    logic [COLOR_W-1:0]   pixel_color;
    logic                 write_enable;
    logic                 last_pixel;
  } out_item_t;

  // Classified command passed from the front to the stepper.
  typedef struct packed {
    action_e                   action;
    logic [COORD_W-1:0]        start_x;
    logic [COORD_W-1:0]        start_y;
    logic [COORD_W-1:0]        end_x;
    logic [COORD_W-1:0]        end_y;
    logic [COLOR_W-1:0]        line_color;
    logic [COORD_W-1:0]        delta_col;
    logic [COORD_W-1:0]        delta_row;
    logic                      col_dir_neg;
    logic                      row_dir_neg;
    logic signed [ERR_W-1:0]   error_term;
  } cmd_t;

  // Occupancy and beat strobes of a queue.
  typedef struct packed {
    logic [QCNT_W-1:0] cnt;
    logic              wr;
    logic              rd;
  } queue_stat_t;

endpackage

@@ design/blg_front.sv @@
// Front end: classifies an input beat and precomputes the line set-up terms.
module blg_front (
  input  blg_pkg::in_item_t item_i,
  output blg_pkg::cmd_t     cmd_o
);

  logic                            col_fwd;
  logic                            row_fwd;
  logic [blg_pkg::COORD_W-1:0]     dx;
  logic [blg_pkg::COORD_W-1:0]     dy;

  // Derive step directions and absolute deltas
  always_comb begin
    col_fwd = item_i.start_x < item_i.end_x;
    row_fwd = item_i.start_y < item_i.end_y;
    dx = col_fwd ? (item_i.end_x - item_i.start_x) : (item_i.start_x - item_i.end_x);
    dy = row_fwd ? (item_i.end_y - item_i.start_y) : (item_i.start_y - item_i.end_y);

    cmd_o.action      = item_i.action;
    cmd_o.start_x     = item_i.start_x;
    cmd_o.start_y     = item_i.start_y;
    cmd_o.end_x       = item_i.end_x;
    cmd_o.end_y       = item_i.end_y;
    cmd_o.line_color  = item_i.line_color;
    cmd_o.delta_col   = dx;
    cmd_o.delta_row   = dy;
    cmd_o.col_dir_neg = !col_fwd;
    cmd_o.row_dir_neg = !row_fwd;
    cmd_o.error_term  = $signed({{(blg_pkg::ERR_W-blg_pkg::COORD_W){1'b0}}, dx})
                      - $signed({{(blg_pkg::ERR_W-blg_pkg::COORD_W){1'b0}}, dy});
  end

endmodule

@@ design/blg_cmd_queue.sv @@
// Short command queue between the front end and the stepper.
module blg_cmd_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  blg_pkg::cmd_t         cmd_i,
  output logic                  full_o,
  output logic                  valid_o,
  output blg_pkg::cmd_t         cmd_o,
  input  logic                  pop_i,
  output blg_pkg::queue_stat_t  stat_o
);

  blg_pkg::cmd_t                 mem_q [blg_pkg::QUEUE_DEPTH];
  logic [blg_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [blg_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [blg_pkg::QCNT_W-1:0]    cnt_q, cnt_d;
  logic                          wr_en;
  logic                          rd_en;

  // Work out beats and next pointers
  always_comb begin
    full_o  = cnt_q == blg_pkg::QCNT_W'(blg_pkg::QUEUE_DEPTH);
    valid_o = cnt_q != '0;
    cmd_o   = mem_q[rd_ptr_q];
    wr_en   = push_i && !full_o;
    rd_en   = pop_i && valid_o;

    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == blg_pkg::QPTR_W'(blg_pkg::QUEUE_DEPTH - 1)) ? '0
               : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == blg_pkg::QPTR_W'(blg_pkg::QUEUE_DEPTH - 1)) ? '0
               : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + blg_pkg::QCNT_W'(wr_en) - blg_pkg::QCNT_W'(rd_en);

    stat_o.cnt = cnt_q;
    stat_o.wr  = wr_en;
    stat_o.rd  = rd_en;
  end

  // Hold pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming command
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ design/blg_back.sv @@
// Back end: Bresenham stepper with its pixel result queue.
module blg_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  blg_pkg::cmd_t         cmd_i,
  output logic                  cmd_pop_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output blg_pkg::out_item_t    result_o,
  output blg_pkg::queue_stat_t  stat_o
);

  localparam int unsigned EW = blg_pkg::ERR_W + 2;
  localparam int unsigned PAD = EW - blg_pkg::COORD_W;

  // Line state
  logic                             active_q, active_d;
  logic [blg_pkg::COORD_W-1:0]      cur_col_q, cur_col_d;
  logic [blg_pkg::COORD_W-1:0]      cur_row_q, cur_row_d;
  logic [blg_pkg::COORD_W-1:0]      goal_col_q, goal_col_d;
  logic [blg_pkg::COORD_W-1:0]      goal_row_q, goal_row_d;
  logic [blg_pkg::COORD_W-1:0]      delta_col_q, delta_col_d;
  logic [blg_pkg::COORD_W-1:0]      delta_row_q, delta_row_d;
  logic                             col_neg_q, col_neg_d;
  logic                             row_neg_q, row_neg_d;
  logic signed [blg_pkg::ERR_W-1:0] err_q, err_d;
  logic [blg_pkg::STEP_W-1:0]       steps_q, steps_d;
  logic [blg_pkg::COLOR_W-1:0]      color_q, color_d;

  // Result queue
  blg_pkg::out_item_t               res_mem_q [blg_pkg::QUEUE_DEPTH];
  logic [blg_pkg::QPTR_W-1:0]       res_wr_q, res_wr_d;
  logic [blg_pkg::QPTR_W-1:0]       res_rd_q, res_rd_d;
  logic [blg_pkg::QCNT_W-1:0]       res_cnt_q, res_cnt_d;
  logic                             res_room;
  logic                             res_rd;

  logic                             is_load;
  logic                             take;
  logic                             emit;
  logic                             on_screen;
  logic                             at_goal;
  logic                             last;
  logic [31:0]                      addr_full;
  logic signed [EW-1:0]             e2;
  logic signed [EW-1:0]             dx_w;
  logic signed [EW-1:0]             dy_w;
  logic signed [EW-1:0]             err_w;
  logic                             col_step;
  logic                             row_step;
  blg_pkg::out_item_t               pix;

  // Emit the pixel at the current point
  always_comb begin
    on_screen = (cur_col_q < blg_pkg::COORD_W'(blg_pkg::SCREEN_WIDTH))
             && (cur_row_q < blg_pkg::COORD_W'(blg_pkg::SCREEN_HEIGHT));
    addr_full = 32'(cur_row_q) * 32'(blg_pkg::SCREEN_WIDTH) + 32'(cur_col_q);
    at_goal   = (cur_col_q == goal_col_q) && (cur_row_q == goal_row_q);
    last      = at_goal || (steps_q >= blg_pkg::STEP_W'(blg_pkg::STEP_LIMIT));

    pix.pixel_x       = cur_col_q;
    pix.pixel_y       = cur_row_q;
    pix.pixel_address = on_screen ? addr_full[blg_pkg::ADDR_W-1:0] : '0;
    pix.pixel_color   = color_q;
    pix.write_enable  = on_screen;
    pix.last_pixel    = last;
  end

  // Decide which axes advance
  always_comb begin
    e2       = {err_q[blg_pkg::ERR_W-1], err_q, 1'b0};
    dx_w     = $signed({{PAD{1'b0}}, delta_col_q});
    dy_w     = $signed({{PAD{1'b0}}, delta_row_q});
    col_step = e2 > -dy_w;
    row_step = e2 < dx_w;
    err_w    = $signed({{2{err_q[blg_pkg::ERR_W-1]}}, err_q})
             - (col_step ? dy_w : '0) + (row_step ? dx_w : '0);
  end

  // Take a command: loads and idle ticks never wait, pixels wait for room
  always_comb begin
    res_room  = res_cnt_q != blg_pkg::QCNT_W'(blg_pkg::QUEUE_DEPTH);
    is_load   = cmd_i.action == blg_pkg::ACT_LOAD;
    take      = cmd_valid_i && (is_load || !active_q || res_room);
    emit      = take && !is_load && active_q;
    cmd_pop_o = take;
  end

  // Advance the line state
  always_comb begin
    active_d    = active_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    goal_col_d  = goal_col_q;
    goal_row_d  = goal_row_q;
    delta_col_d = delta_col_q;
    delta_row_d = delta_row_q;
    col_neg_d   = col_neg_q;
    row_neg_d   = row_neg_q;
    err_d       = err_q;
    steps_d     = steps_q;
    color_d     = color_q;
    if (take && is_load) begin
      active_d    = 1'b1;
      cur_col_d   = cmd_i.start_x;
      cur_row_d   = cmd_i.start_y;
      goal_col_d  = cmd_i.end_x;
      goal_row_d  = cmd_i.end_y;
      delta_col_d = cmd_i.delta_col;
      delta_row_d = cmd_i.delta_row;
      col_neg_d   = cmd_i.col_dir_neg;
      row_neg_d   = cmd_i.row_dir_neg;
      err_d       = cmd_i.error_term;
      steps_d     = '0;
      color_d     = cmd_i.line_color;
    end else if (emit) begin
      if (last) begin
        active_d = 1'b0;
      end else begin
        err_d   = err_w[blg_pkg::ERR_W-1:0];
        steps_d = steps_q + 1'b1;
        if (col_step) begin
          cur_col_d = col_neg_q ? cur_col_q - 1'b1 : cur_col_q + 1'b1;
        end
        if (row_step) begin
          cur_row_d = row_neg_q ? cur_row_q - 1'b1 : cur_row_q + 1'b1;
        end
      end
    end
  end

  // Result queue pointers and occupancy
  always_comb begin
    empty_o  = res_cnt_q == '0;
    result_o = res_mem_q[res_rd_q];
    res_rd   = pop_i && !empty_o;
    res_wr_d = res_wr_q;
    res_rd_d = res_rd_q;
    if (emit) begin
      res_wr_d = (res_wr_q == blg_pkg::QPTR_W'(blg_pkg::QUEUE_DEPTH - 1)) ? '0
               : res_wr_q + 1'b1;
    end
    if (res_rd) begin
      res_rd_d = (res_rd_q == blg_pkg::QPTR_W'(blg_pkg::QUEUE_DEPTH - 1)) ? '0
               : res_rd_q + 1'b1;
    end
    res_cnt_d = res_cnt_q + blg_pkg::QCNT_W'(emit) - blg_pkg::QCNT_W'(res_rd);

    stat_o.cnt = res_cnt_q;
    stat_o.wr  = emit;
    stat_o.rd  = res_rd;
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      goal_col_q  <= '0;
      goal_row_q  <= '0;
      delta_col_q <= '0;
      delta_row_q <= '0;
      col_neg_q   <= 1'b0;
      row_neg_q   <= 1'b0;
      err_q       <= '0;
      steps_q     <= '0;
      color_q     <= '0;
      res_wr_q    <= '0;
      res_rd_q    <= '0;
      res_cnt_q   <= '0;
    end else begin
      active_q    <= active_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      goal_col_q  <= goal_col_d;
      goal_row_q  <= goal_row_d;
      delta_col_q <= delta_col_d;
      delta_row_q <= delta_row_d;
      col_neg_q   <= col_neg_d;
      row_neg_q   <= row_neg_d;
      err_q       <= err_d;
      steps_q     <= steps_d;
      color_q     <= color_d;
      res_wr_q    <= res_wr_d;
      res_rd_q    <= res_rd_d;
      res_cnt_q   <= res_cnt_d;
    end
  end

  // Store the emitted pixel
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_mem_q[res_wr_q] <= pix;
    end
  end

endmodule

@@ design/bresenham_line_pixel_generator.sv @@
// Bresenham line pixel generator, top level.
//
// Input channel (push/full): each beat is a load, which latches a line
// command (endpoints and colour), or a tick, which asks for the next pixel.
// Result channel (empty/pop): one pixel beat per tick while a line runs,
// with column, row, framebuffer address, colour, write enable (low for a
// pixel off the screen, address then 0) and a flag on the run's last pixel.
// A load or a tick with no line running gives no result beat.
// An accepted tick is registered in the command queue, then its pixel is
// registered in the result queue, from which it can be popped.
// Throughput: one item per cycle while neither queue stalls; the stepper
// updates the error term and both coordinates at once, and each side of it
// has a two-entry queue so input and output can stall on their own.
// Reset clears the line state and both queues: empty is high, full low,
// and ticks are dropped until the first load.
// When the receiver stops popping, the result queue fills, the stepper holds
// the next tick, the command queue fills and full rises; no beat is lost.
`include "assert_macros.svh"

module bresenham_line_pixel_generator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  blg_pkg::in_item_t   item_i,
  output logic                empty,
  input  logic                pop,
  output blg_pkg::out_item_t  result_o
);

  blg_pkg::cmd_t         front_cmd;
  blg_pkg::cmd_t         head_cmd;
  logic                  head_valid;
  logic                  head_pop;
  blg_pkg::queue_stat_t  cmd_stat;
  blg_pkg::queue_stat_t  res_stat;

  logic [blg_pkg::QCNT_W-1:0] cmd_nxt;
  logic [blg_pkg::QCNT_W-1:0] res_nxt;
  logic                       head_we;
  logic                       head_off;
  logic                       head_on_screen;

  blg_front u_front (
    .item_i (item_i),
    .cmd_o  (front_cmd)
  );

  blg_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .valid_o (head_valid),
    .cmd_o   (head_cmd),
    .pop_i   (head_pop),
    .stat_o  (cmd_stat)
  );

  blg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (head_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o),
    .stat_o      (res_stat)
  );

  // Expected next occupancies and clip terms of the result at the head
  always_comb begin
    cmd_nxt = cmd_stat.cnt + blg_pkg::QCNT_W'(cmd_stat.wr)
            - blg_pkg::QCNT_W'(cmd_stat.rd);
    res_nxt = res_stat.cnt + blg_pkg::QCNT_W'(res_stat.wr)
            - blg_pkg::QCNT_W'(res_stat.rd);
    head_we  = !empty && result_o.write_enable;
    head_off = !empty && !result_o.write_enable;
    head_on_screen = (result_o.pixel_x < blg_pkg::COORD_W'(blg_pkg::SCREEN_WIDTH))
                  && (result_o.pixel_y < blg_pkg::COORD_W'(blg_pkg::SCREEN_HEIGHT));
  end

  `BLG_ASSERT_RST(a_reset_idle, clk_i, rst_ni, empty && !full, "queues not cleared in reset")
  `BLG_ASSERT(a_cmd_count, clk_i, rst_ni, 1'b1 |=> cmd_stat.cnt == $past(cmd_nxt), "cmd count")
  `BLG_ASSERT(a_res_count, clk_i, rst_ni, 1'b1 |=> res_stat.cnt == $past(res_nxt), "res count")
  `BLG_ASSERT(a_clip, clk_i, rst_ni, head_we |-> head_on_screen, "enabled pixel off screen")
  `BLG_ASSERT(a_clip_addr, clk_i, rst_ni, head_off |-> result_o.pixel_address == '0, "clip addr")

endmodule
